// File: rtl/core/bounded_key_list_engine_macros.svh
// Assertion macros for the bounded key list engine.
// Depends on nothing; included by the top level, which supplies i_clk and i_rst_n.
`ifndef BOUNDED_KEY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_KEY_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define BKLE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bkle check failed");
`define BKLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bkle check failed");
`else
`define BKLE_ASSERT(label, prop)
`define BKLE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/bkle_pkg.sv
// Shared types and codes for the bounded key list engine.
// Depends on nothing.
`timescale 1ns / 1ps
package bkle_pkg;
    localparam int unsigned DEPTH_DEF = 16;

    typedef enum logic [3:0] {
        CMD_INS_HEAD   = 4'd0,
        CMD_INS_TAIL   = 4'd1,
        CMD_INS_SORTED = 4'd2,
        CMD_REM_HEAD   = 4'd3,
        CMD_REM_TAIL   = 4'd4,
        CMD_REM_KEY    = 4'd5,
        CMD_CONTAINS   = 4'd6,
        CMD_ITER_START = 4'd7,
        CMD_ITER_NEXT  = 4'd8,
        CMD_QUERY      = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] key;
    } t_cmd_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] key_out;
        logic [4:0]         count;
        logic               is_empty;
    } t_result;
endpackage

// File: rtl/core/bkle_ram.sv
// Single-port-write, single-port-read key store with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module bkle_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [31:0]  i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [31:0]  o_rdata
);
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/bounded_key_list_engine.sv
// Top level of the bounded key list engine: command sequencer and result register.
// Depends on bkle_pkg, bkle_ram and bounded_key_list_engine_macros.svh.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_cmd_in)
//  out     | output    | o_out_valid / i_out_ready   | o_out_data (t_result)
//
// One command is worked at a time. Query, iterator start and full/empty refusals
// go straight to the done state; insert at tail first writes the new key, iterator
// next reads and checks one entry, and remove at head or tail reads its entry and
// then moves each later entry down by a read and a write. A scan reads and checks
// each entry looked at, and a shift reads and writes each entry moved, as the single
// key memory gives one read (with registered data) and one write per cycle.
// Reset is synchronous and empties the list and exhausts the iterator; the memory
// itself is not cleared, since only entries below the fill count are ever read.
// A result waits in the output register until transferred; the next command is
// taken meanwhile and is held in its final state only if the register is still full.
`timescale 1ns / 1ps
`include "bounded_key_list_engine_macros.svh"
module bounded_key_list_engine #(
    parameter int unsigned DEPTH = bkle_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bkle_pkg::t_cmd_in i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bkle_pkg::t_result o_out_data
);
    import bkle_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned FW = $clog2(DEPTH + 1);

    // Sequencer states. Every state that reads the memory is followed by one that
    // consumes the registered read data.
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_FETCH_RD, S_FETCH_CHK,
        S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_WR_NEW, S_REM_FIN, S_DONE
    } t_state;

    t_state             r_state;
    logic [3:0]         r_cmd;
    logic signed [31:0] r_key;
    logic [FW-1:0]      r_fill;
    logic [FW-1:0]      r_iter_pos;
    logic               r_iter_live;
    logic [FW-1:0]      r_idx;
    logic [FW-1:0]      r_pos;
    logic [1:0]         r_status;
    logic signed [31:0] r_kout;
    logic               r_out_valid;
    t_result            r_out_data;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic signed [31:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic signed [31:0] ram_rdata;
    logic [FW-1:0]      n_idx;
    logic [FW:0]        idx_plus2;
    logic               scan_hit;
    logic [FW-1:0]      n_iter_pos;

    bkle_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign n_idx     = r_idx + FW'(1);
    assign idx_plus2 = {1'b0, r_idx} + (FW + 1)'(2);

    // Sorted insert stops at the first key not below the new one; the other scans
    // stop at an exact match.
    assign scan_hit = (r_cmd == CMD_INS_SORTED) ? (ram_rdata >= r_key)
                                                : (ram_rdata == r_key);

    // Iterator position after removing the entry at r_pos.
    assign n_iter_pos = (r_iter_pos > r_pos) ? r_iter_pos - FW'(1) : r_iter_pos;

    // Memory port control follows the state directly.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];
        case (r_state)
            S_FETCH_RD: ram_raddr = r_pos[AW-1:0];
            S_UP_RD:    ram_raddr = AW'(r_idx - FW'(1));
            S_UP_WR:    ram_we = 1'b1;
            S_DN_RD:    ram_raddr = n_idx[AW-1:0];
            S_DN_WR:    ram_we = 1'b1;
            S_WR_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = r_key;
            end
            default:    ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_iter_pos  <= '0;
            r_iter_live <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The done state decides the output register itself.
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_in_data.cmd;
                        r_key    <= i_in_data.key;
                        r_status <= ST_OK;
                        r_kout   <= '0;
                        r_idx    <= '0;
                        r_state  <= S_DONE;
                        unique case (i_in_data.cmd) inside
                            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_SORTED: begin
                                if (r_fill == FW'(DEPTH)) begin
                                    r_status <= ST_FULL;
                                end else if (i_in_data.cmd == CMD_INS_HEAD) begin
                                    r_pos   <= '0;
                                    r_idx   <= r_fill;
                                    r_state <= (r_fill == '0) ? S_WR_NEW : S_UP_RD;
                                end else if (i_in_data.cmd == CMD_INS_TAIL
                                             || r_fill == '0) begin
                                    r_pos   <= r_fill;
                                    r_state <= S_WR_NEW;
                                end else begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            CMD_REM_HEAD, CMD_REM_TAIL: begin
                                if (r_fill == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_pos   <= (i_in_data.cmd == CMD_REM_HEAD)
                                               ? '0 : r_fill - FW'(1);
                                    r_state <= S_FETCH_RD;
                                end
                            end
                            CMD_REM_KEY, CMD_CONTAINS: begin
                                if (r_fill == '0) begin
                                    r_status <= (i_in_data.cmd == CMD_REM_KEY)
                                                ? ST_EMPTY : ST_NOTFOUND;
                                end else begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            CMD_ITER_START: begin
                                r_iter_pos  <= '0;
                                r_iter_live <= (r_fill != '0);
                                if (r_fill == '0) begin
                                    r_status <= ST_EMPTY;
                                end
                            end
                            CMD_ITER_NEXT: begin
                                if (!r_iter_live || r_iter_pos >= r_fill) begin
                                    r_iter_live <= 1'b0;
                                    r_status    <= ST_EMPTY;
                                end else begin
                                    r_pos   <= r_iter_pos;
                                    r_state <= S_FETCH_RD;
                                end
                            end
                            default: r_status <= ST_OK;
                        endcase
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (scan_hit) begin
                        r_pos <= r_idx;
                        if (r_cmd == CMD_INS_SORTED) begin
                            r_idx   <= r_fill;
                            r_state <= S_UP_RD;
                        end else if (r_cmd == CMD_REM_KEY) begin
                            r_state <= (n_idx < r_fill) ? S_DN_RD : S_REM_FIN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (n_idx == r_fill) begin
                        if (r_cmd == CMD_INS_SORTED) begin
                            r_pos   <= r_fill;
                            r_state <= S_WR_NEW;
                        end else begin
                            r_status <= ST_NOTFOUND;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_idx   <= n_idx;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_FETCH_RD: r_state <= S_FETCH_CHK;
                S_FETCH_CHK: begin
                    r_kout <= ram_rdata;
                    if (r_cmd == CMD_ITER_NEXT) begin
                        r_iter_pos <= r_iter_pos + FW'(1);
                        if (r_iter_pos + FW'(1) >= r_fill) begin
                            r_iter_live <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_pos;
                        r_state <= (r_pos + FW'(1) < r_fill) ? S_DN_RD : S_REM_FIN;
                    end
                end
                S_UP_RD: r_state <= S_UP_WR;
                S_UP_WR: begin
                    r_idx   <= r_idx - FW'(1);
                    r_state <= (r_idx - FW'(1) == r_pos) ? S_WR_NEW : S_UP_RD;
                end
                S_DN_RD: r_state <= S_DN_WR;
                S_DN_WR: begin
                    r_idx   <= n_idx;
                    r_state <= (idx_plus2 < {1'b0, r_fill}) ? S_DN_RD : S_REM_FIN;
                end
                S_WR_NEW: begin
                    r_fill <= r_fill + FW'(1);
                    if (r_iter_live && r_iter_pos >= r_pos) begin
                        r_iter_pos <= r_iter_pos + FW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_REM_FIN: begin
                    r_fill <= r_fill - FW'(1);
                    if (r_iter_live) begin
                        r_iter_pos <= n_iter_pos;
                        if (n_iter_pos >= r_fill - FW'(1)) begin
                            r_iter_live <= 1'b0;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Load the result once the output register is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid         <= 1'b1;
                        r_out_data.status   <= r_status;
                        r_out_data.key_out  <= r_kout;
                        r_out_data.count    <= 5'(r_fill);
                        r_out_data.is_empty <= (r_fill == '0);
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The fill count never passes the capacity, and a live iterator always points
    // at a held entry; every accepted command leaves the idle state.
    `BKLE_ASSERT(a_fill_bound, r_fill <= FW'(DEPTH))
    `BKLE_ASSERT(a_iter_in_range, r_iter_live |-> (r_iter_pos < r_fill))
    `BKLE_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, r_state != S_IDLE)
endmodule

// File: tb/bounded_key_list_engine_tb.sv
// Self-checking testbench for the bounded key list engine: directed and random commands.
// Depends on bkle_pkg and the bounded_key_list_engine top level.
`timescale 1ns / 1ps

// Keeps a shadow copy of the key list and the queue of results it predicts.
class key_list_scoreboard;
    logic signed [31:0]   keys[$];
    int unsigned          iter_idx;
    bit                   iter_on;
    bkle_pkg::t_result    pending[$];
    int                   errors;
    int                   results_seen;

    function new();
        iter_idx = 0;
        iter_on = 0;
        errors = 0;
        results_seen = 0;
    endfunction

    // Removes the key at position p and keeps the iterator on its element.
    function logic signed [31:0] take_at(int unsigned p);
        logic signed [31:0] k;
        k = keys[p];
        keys.delete(p);
        if (iter_on) begin
            if (iter_idx > p) iter_idx--;
            if (iter_idx >= keys.size()) iter_on = 0;
        end
        return k;
    endfunction

    // Works out the result of one accepted command and queues it.
    function void note_command(bkle_pkg::t_cmd_in c);
        bkle_pkg::t_result r;
        int unsigned p;
        int f;
        r = '0;
        r.status = bkle_pkg::ST_OK;
        f = -1;
        foreach (keys[i]) if (f < 0 && keys[i] == c.key) f = i;
        case (c.cmd)
            bkle_pkg::CMD_INS_HEAD, bkle_pkg::CMD_INS_TAIL, bkle_pkg::CMD_INS_SORTED: begin
                if (keys.size() >= bkle_pkg::DEPTH_DEF) begin
                    r.status = bkle_pkg::ST_FULL;
                end else begin
                    if (c.cmd == bkle_pkg::CMD_INS_HEAD) p = 0;
                    else if (c.cmd == bkle_pkg::CMD_INS_TAIL) p = keys.size();
                    else begin
                        p = 0;
                        while (p < keys.size() && keys[p] < c.key) p++;
                    end
                    keys.insert(p, c.key);
                    if (iter_on && iter_idx >= p) iter_idx++;
                end
            end
            bkle_pkg::CMD_REM_HEAD: begin
                if (keys.size() == 0) r.status = bkle_pkg::ST_EMPTY;
                else r.key_out = take_at(0);
            end
            bkle_pkg::CMD_REM_TAIL: begin
                if (keys.size() == 0) r.status = bkle_pkg::ST_EMPTY;
                else r.key_out = take_at(keys.size() - 1);
            end
            bkle_pkg::CMD_REM_KEY: begin
                if (keys.size() == 0) r.status = bkle_pkg::ST_EMPTY;
                else if (f < 0) r.status = bkle_pkg::ST_NOTFOUND;
                else void'(take_at(f));
            end
            bkle_pkg::CMD_CONTAINS: begin
                if (f < 0) r.status = bkle_pkg::ST_NOTFOUND;
            end
            bkle_pkg::CMD_ITER_START: begin
                iter_idx = 0;
                iter_on = (keys.size() > 0);
                if (!iter_on) r.status = bkle_pkg::ST_EMPTY;
            end
            bkle_pkg::CMD_ITER_NEXT: begin
                if (!iter_on || iter_idx >= keys.size()) begin
                    iter_on = 0;
                    r.status = bkle_pkg::ST_EMPTY;
                end else begin
                    r.key_out = keys[iter_idx];
                    iter_idx++;
                    if (iter_idx >= keys.size()) iter_on = 0;
                end
            end
            default: ;
        endcase
        r.count = 5'(keys.size());
        r.is_empty = (keys.size() == 0);
        pending.push_back(r);
    endfunction

    // Compares one transferred result with the oldest prediction.
    function void check_result(bkle_pkg::t_result got);
        bkle_pkg::t_result exp;
        results_seen++;
        if (pending.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            errors++;
        end
        if (got.key_out !== exp.key_out) begin
            $error("key_out: expected %0d, actual %0d", exp.key_out, got.key_out);
            errors++;
        end
        if (got.count !== exp.count) begin
            $error("count: expected %0d, actual %0d", exp.count, got.count);
            errors++;
        end
        if (got.is_empty !== exp.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", exp.is_empty, got.is_empty);
            errors++;
        end
    endfunction
endclass

module bounded_key_list_engine_tb;
    import bkle_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    t_cmd_in in_data;
    logic    out_valid;
    logic    out_ready;
    t_result out_data;

    key_list_scoreboard board;
    int      sent = 0;
    bit      stall_on = 1'b0;

    bounded_key_list_engine u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // 2 ns clock period.
    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Every transfer on either channel is seen at the rising edge; the input side
    // feeds the predictor, and the output side is checked against it.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            board.note_command(in_data);
            sent++;
        end
        if (rst_n && out_valid && out_ready) begin
            board.check_result(out_data);
        end
    end

    // The receiver stalls on its own pattern: runs of random pressure separated by
    // stretches where it is always ready. Changes are made on the falling edge.
    always @(negedge clk) begin
        if ($urandom_range(0, 99) == 0) stall_on = !stall_on;
        if (!rst_n) out_ready <= 1'b0;
        else if (stall_on) out_ready <= ($urandom_range(0, 2) != 0);
        else out_ready <= 1'b1;
    end

    // Drives one command and holds it until the transfer completes.
    task automatic send_command(input t_cmd c, input logic signed [31:0] k);
        in_data.cmd <= c;
        in_data.key <= k;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Raw code version, so that unused codes are reached too.
    task automatic send_raw(input logic [3:0] c, input logic signed [31:0] k);
        in_data.cmd <= c;
        in_data.key <= k;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drops valid for a pause between bursts; the caller picks its length at random.
    task automatic pause_sender(input int unsigned n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Waits for every outstanding prediction to be matched.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
    endtask

    // Keys are mostly drawn from a small pool so that matches and duplicates
    // are common, with full-range values and the extremes mixed in.
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return $urandom();
            default: return $signed($urandom_range(0, 12)) - 6;
        endcase
    endfunction

    // Command mix leans toward inserts or removals depending on the phase so the
    // list both fills up and empties out often.
    function automatic logic [3:0] pick_cmd(input bit grow);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2) return 4'($urandom_range(10, 15));
        if (r < 40) return grow ? 4'($urandom_range(0, 2)) : 4'($urandom_range(3, 5));
        return 4'($urandom_range(0, 9));
    endfunction

    initial begin
        int unsigned burst;
        bit grow;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-store cases, extreme keys, a full store and the
        // iterator following its element across removals.
        send_command(CMD_REM_HEAD, 0);
        send_command(CMD_REM_TAIL, 0);
        send_command(CMD_REM_KEY, 5);
        send_command(CMD_ITER_START, 0);
        send_command(CMD_ITER_NEXT, 0);
        send_command(CMD_INS_SORTED, 32'sh7fff_ffff);
        send_command(CMD_INS_SORTED, 32'sh8000_0000);
        send_command(CMD_INS_HEAD, -1);
        send_command(CMD_INS_TAIL, 0);
        send_command(CMD_CONTAINS, 32'sh8000_0000);
        send_command(CMD_CONTAINS, 77);
        send_command(CMD_REM_KEY, 77);
        send_command(CMD_ITER_START, 0);
        send_command(CMD_ITER_NEXT, 0);
        send_command(CMD_REM_KEY, -1);
        send_command(CMD_ITER_NEXT, 0);
        send_command(CMD_QUERY, 0);
        send_raw(4'd15, 32'sh5555_aaaa);
        for (int i = 0; i < 14; i++) send_command(CMD_INS_TAIL, i);
        send_command(CMD_INS_HEAD, 99);
        send_command(CMD_REM_HEAD, 0);
        send_command(CMD_REM_TAIL, 0);
        send_command(CMD_ITER_START, 0);

        // The sender holds off until the engine has caught up.
        drain_results();

        grow = 1'b1;
        while (sent < 1200) begin
            burst = $urandom_range(1, 30);
            if ($urandom_range(0, 5) == 0) grow = !grow;
            repeat (burst) send_raw(pick_cmd(grow), pick_key());
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        end

        drain_results();
        repeat (100) @(negedge clk);
        $display("Covered %0d commands and %0d results over fill, drain and iterator walks.",
                 sent, board.results_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // The timeout leaves room for the longest commands plus receiver stalls.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule

// File: bounded_key_list_engine.f
+incdir+rtl/core
rtl/core/bkle_pkg.sv
rtl/core/bkle_ram.sv
rtl/core/bounded_key_list_engine.sv
tb/bounded_key_list_engine_tb.sv
